// ===== design/nsrc_pkg.sv =====
// nsrc_pkg: shared widths, register indexes, control/status structs and the
// sample format conversion for the nearest sample rate converter
// no dependencies
package nsrc_pkg;

    // field and state widths
    localparam int SAMPLE_W   = 16;
    localparam int STEP_W     = 11;
    localparam int COUNT_W    = 20;
    localparam int POS_W      = 32;
    localparam int FRAC_W     = 8;
    localparam int INDEX_W    = POS_W - FRAC_W;
    localparam int BURST_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    // smallest usable step, bounds a burst at four outputs
    localparam logic [STEP_W-1:0]  STEP_MIN   = 11'd64;
    localparam logic [STEP_W-1:0]  STEP_RESET = 11'd256;
    localparam logic [BURST_W-1:0] BURST_LAST = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STEP      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IN_16BIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_16BIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_COUNT = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic capture;   // take the input sample, start a burst
        logic emit;      // load one output and advance position and count
        logic idx_inc;   // advance the source index, burst over
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic first_ok;  // current position matches the index, count not reached
        logic next_ok;   // another output follows the one being emitted
        logic out_free;  // output register can take a new transaction
    } t_status;

    // raw input to output format: recenter 8-bit input, narrow to 8-bit output
    function automatic logic [SAMPLE_W-1:0] convert(logic [SAMPLE_W-1:0] raw,
                                                    logic in16, logic out16);
        logic [SAMPLE_W-1:0] v16;
        logic [SAMPLE_W-1:0] res;
        v16 = in16 ? raw : {~raw[7], raw[6:0], 8'h00};
        res = out16 ? v16 : {{8{v16[15]}}, v16[15:8]};
        return res;
    endfunction

endpackage

// ===== design/nsrc_in_if.sv =====
// nsrc_in_if: source sample channel, valid/ready handshake
// depends on nsrc_pkg
interface nsrc_in_if;
    logic                          valid;
    logic                          ready;
    logic [nsrc_pkg::SAMPLE_W-1:0] in_sample;

    modport source (output valid, output in_sample, input ready);
    modport sink   (input valid, input in_sample, output ready);
endinterface

// ===== design/nsrc_out_if.sv =====
// nsrc_out_if: converted sample channel, valid/ready handshake
// depends on nsrc_pkg
interface nsrc_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [nsrc_pkg::SAMPLE_W-1:0] out_sample;
    logic                                 run_last;
    logic                                 sound_done;

    modport source (output valid, output out_sample, output run_last,
                    output sound_done, input ready);
    modport sink   (input valid, input out_sample, input run_last,
                    input sound_done, output ready);
endinterface

// ===== design/nsrc_datapath.sv =====
// nsrc_datapath: configuration registers, read position, source index,
// output count, burst counter and the output register
// depends on nsrc_pkg
module nsrc_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [nsrc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [nsrc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [nsrc_pkg::SAMPLE_W-1:0]    i_in_sample,
    input  nsrc_pkg::t_cmd                   i_cmd,
    output nsrc_pkg::t_status                o_status,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic signed [nsrc_pkg::SAMPLE_W-1:0] o_out_sample,
    output logic                             o_run_last,
    output logic                             o_sound_done
);

    logic [nsrc_pkg::STEP_W-1:0]   r_step;
    logic                          r_in16;
    logic                          r_out16;
    logic [nsrc_pkg::COUNT_W-1:0]  r_out_count;
    logic [nsrc_pkg::POS_W-1:0]    r_pos;
    logic [nsrc_pkg::INDEX_W-1:0]  r_idx;
    logic [nsrc_pkg::COUNT_W-1:0]  r_emitted;
    logic [nsrc_pkg::BURST_W-1:0]  r_n;
    logic [nsrc_pkg::SAMPLE_W-1:0] r_sample;
    logic                          r_out_valid;
    logic [nsrc_pkg::SAMPLE_W-1:0] r_out_sample;
    logic                          r_run_last;
    logic                          r_sound_done;

    logic [nsrc_pkg::STEP_W-1:0]   w_step;
    logic [nsrc_pkg::POS_W-1:0]    n_pos;
    logic [nsrc_pkg::COUNT_W-1:0]  n_emitted;
    logic                          w_out_free;

    // clamped step and the values after one more output
    assign w_step    = (r_step < nsrc_pkg::STEP_MIN) ? nsrc_pkg::STEP_MIN : r_step;
    assign n_pos     = r_pos + {{(nsrc_pkg::POS_W-nsrc_pkg::STEP_W){1'b0}}, w_step};
    assign n_emitted = r_emitted + {{(nsrc_pkg::COUNT_W-1){1'b0}}, 1'b1};
    assign w_out_free = !r_out_valid || i_out_ready;

    // status for the controller
    always_comb begin
        o_status.first_ok = (r_emitted < r_out_count) &&
                            (r_pos[nsrc_pkg::POS_W-1:nsrc_pkg::FRAC_W] == r_idx);
        o_status.next_ok  = (r_n != nsrc_pkg::BURST_LAST) &&
                            (n_emitted < r_out_count) &&
                            (n_pos[nsrc_pkg::POS_W-1:nsrc_pkg::FRAC_W] == r_idx);
        o_status.out_free = w_out_free;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= nsrc_pkg::STEP_RESET;
            r_in16      <= 1'b0;
            r_out16     <= 1'b0;
            r_out_count <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                nsrc_pkg::REG_STEP:      r_step      <= i_cfg_data[nsrc_pkg::STEP_W-1:0];
                nsrc_pkg::REG_IN_16BIT:  r_in16      <= i_cfg_data[0];
                nsrc_pkg::REG_OUT_16BIT: r_out16     <= i_cfg_data[0];
                nsrc_pkg::REG_OUT_COUNT: r_out_count <= i_cfg_data[nsrc_pkg::COUNT_W-1:0];
            endcase
        end
    end

    // position, index, count and burst counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_idx     <= '0;
            r_emitted <= '0;
            r_n       <= '0;
        end else begin
            if (i_cmd.capture) begin
                r_n <= '0;
            end else if (i_cmd.emit) begin
                r_n <= r_n + {{(nsrc_pkg::BURST_W-1){1'b0}}, 1'b1};
            end
            if (i_cmd.emit) begin
                r_pos     <= n_pos;
                r_emitted <= n_emitted;
            end
            if (i_cmd.idx_inc) begin
                r_idx <= r_idx + {{(nsrc_pkg::INDEX_W-1){1'b0}}, 1'b1};
            end
        end
    end

    // converted sample held for the burst
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sample <= nsrc_pkg::convert(i_in_sample, r_in16, r_out16);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_sample <= r_sample;
            r_run_last   <= !o_status.next_ok;
            r_sound_done <= (n_emitted == r_out_count);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_sample = $signed(r_out_sample);
    assign o_run_last   = r_run_last;
    assign o_sound_done = r_sound_done;

endmodule

// ===== design/nsrc_controller.sv =====
// nsrc_controller: state machine that takes a source sample and sequences
// its burst of outputs through the datapath
// depends on nsrc_pkg
module nsrc_controller (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  nsrc_pkg::t_status i_status,
    output nsrc_pkg::t_cmd    o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic r_state;
    logic n_state;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    if (i_status.first_ok) begin
                        n_state = ST_EMIT;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                    end
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (!i_status.next_ok) begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = ST_IDLE;
                    end
                end
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // an output is only loaded when the output register can take it
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_status.out_free)
        else $error("emit while output register busy");

    // during a burst the index only moves with its final output
    a_idx_with_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.idx_inc && r_state == ST_EMIT) |-> o_cmd.emit)
        else $error("index advanced without final output");

    // a matching sample always starts a burst
    a_burst_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.capture && i_status.first_ok) |=> (r_state == ST_EMIT))
        else $error("burst not started");

endmodule

// ===== design/nearest_sample_rate_converter_unit.sv =====
// nearest_sample_rate_converter_unit: top level, controller plus datapath
// depends on nsrc_pkg, nsrc_in_if, nsrc_out_if, nsrc_controller, nsrc_datapath
//
// Nearest-neighbor sample rate converter for mono PCM. Each source sample
// transaction produces every output whose 24.8 read position falls on that
// sample's index, up to four, until out_count outputs have been produced.
// Outputs leave one per cycle, while the output channel takes them, from a
// single output register, and a new sample is taken only after the last
// output of the previous one is loaded; backpressure on the output channel
// stalls the burst. Write the configuration registers only while the block
// is idle; after reset the block is ready at once.
module nearest_sample_rate_converter_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [nsrc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [nsrc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    nsrc_in_if.sink                         i_in,
    nsrc_out_if.source                      o_out
);

    nsrc_pkg::t_cmd    w_cmd;
    nsrc_pkg::t_status w_status;

    // sequencing
    nsrc_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // state and output register
    nsrc_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_sample  (i_in.in_sample),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .o_out_sample (o_out.out_sample),
        .o_run_last   (o_out.run_last),
        .o_sound_done (o_out.sound_done)
    );

endmodule
